// ===== rtl/cdt_pkg.sv =====
package cdt_pkg;

	localparam int CNT_W      = 10;
	localparam int KEY_W      = 4;
	localparam int SEG_W      = 8;
	localparam int DIG_W      = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;

	// Kind of request carried in req_type.
	typedef enum logic {
		REQ_TICK = 1'b0,
		REQ_KEY  = 1'b1
	} req_kind_t;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TENTH_PERIOD = 2'd0,
		CFG_MUX_PERIOD   = 2'd1,
		CFG_ADJUST_STEP  = 2'd2
	} cfg_reg_t;

	// Decoded key positions that the timer reacts to.
	localparam logic [KEY_W-1:0] KEY_PAUSE = 4'd0;
	localparam logic [KEY_W-1:0] KEY_UP    = 4'd4;
	localparam logic [KEY_W-1:0] KEY_DOWN  = 4'd8;

	localparam logic [7:0]       TENTH_PERIOD_RST = 8'd25;
	localparam logic [3:0]       MUX_PERIOD_RST   = 4'd1;
	localparam logic [7:0]       ADJUST_STEP_RST  = 8'd10;
	localparam logic [CNT_W-1:0] REMAIN_RST       = 10'd200;
	localparam logic [CNT_W-1:0] SPLIT_LIMIT      = 10'd100;
	localparam logic [SEG_W-1:0] SEG_DP           = 8'h80;

	typedef struct packed {
		logic [7:0] tenth_period;
		logic [3:0] mux_period;
		logic [7:0] adjust_step;
	} cfg_t;

	// Timer state after one request has been applied.
	typedef struct packed {
		logic [CNT_W-1:0] remaining;
		logic             digit_pick;
		logic             hold;
	} snap_t;

	function automatic logic [SEG_W-1:0] seg_font(input logic [3:0] digit);
		logic [SEG_W-1:0] pat;
		case (digit)
			4'd0: pat = 8'h3F;
			4'd1: pat = 8'h06;
			4'd2: pat = 8'h5B;
			4'd3: pat = 8'h4F;
			4'd4: pat = 8'h66;
			4'd5: pat = 8'h6D;
			4'd6: pat = 8'h7D;
			4'd7: pat = 8'h07;
			4'd8: pat = 8'h7F;
			4'd9: pat = 8'h6F;
			default: pat = 8'h00;
		endcase
		return pat;
	endfunction

endpackage

// ===== rtl/cdt_req_if.sv =====
interface cdt_req_if;
	logic                      valid;
	logic                      ready;
	logic                      req_type;
	logic [cdt_pkg::KEY_W-1:0] key_index;

	modport source(output valid, req_type, key_index, input ready);
	modport sink(input valid, req_type, key_index, output ready);
endinterface

// ===== rtl/cdt_res_if.sv =====
interface cdt_res_if;
	logic                      valid;
	logic                      ready;
	logic [cdt_pkg::DIG_W-1:0] digit_enable;
	logic [cdt_pkg::SEG_W-1:0] segments;
	logic [cdt_pkg::CNT_W-1:0] count_value;
	logic                      paused;

	modport source(output valid, digit_enable, segments, count_value, paused, input ready);
	modport sink(input valid, digit_enable, segments, count_value, paused, output ready);
endinterface

// ===== rtl/cdt_cfg_if.sv =====
interface cdt_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [cdt_pkg::CFG_IDX_W-1:0]  index;
	logic [cdt_pkg::CFG_DATA_W-1:0] data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// ===== rtl/cdt_ctrl.sv =====
module cdt_ctrl #(
	parameter int MAX_COUNT = 999
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      fire,
	input  logic                      req_type,
	input  logic [cdt_pkg::KEY_W-1:0] key_index,
	input  cdt_pkg::cfg_t             cfg,
	output cdt_pkg::snap_t            snap_s2
);
	import cdt_pkg::*;

	localparam logic [CNT_W:0] MAX_SUM = (CNT_W + 1)'(MAX_COUNT);

	logic [CNT_W-1:0] remaining_q, remaining_d;
	logic             hold_q, hold_d;
	logic [7:0]       tenth_q, tenth_d;
	logic [3:0]       mux_q, mux_d;
	logic             pick_q, pick_d;

	logic [4:0]       next_mux;
	logic [8:0]       next_tenth;
	logic [CNT_W:0]   sum;

	always_comb begin
		remaining_d = remaining_q;
		hold_d      = hold_q;
		tenth_d     = tenth_q;
		mux_d       = mux_q;
		pick_d      = pick_q;
		next_mux    = {1'b0, mux_q} + 5'd1;
		next_tenth  = {1'b0, tenth_q} + 9'd1;
		sum         = {1'b0, remaining_q} + {3'b000, cfg.adjust_step};

		if (req_type == REQ_TICK) begin
			if (next_mux > {1'b0, cfg.mux_period}) begin
				pick_d = ~pick_q;
				mux_d  = 4'd0;
			end else begin
				mux_d = next_mux[3:0];
			end
			// The tenth prescaler saturates rather than wrapping while paused.
			if (next_tenth > {1'b0, cfg.tenth_period} && !hold_q) begin
				if (remaining_q != '0) begin
					remaining_d = remaining_q - 1'b1;
				end
				tenth_d = 8'd0;
			end else begin
				tenth_d = next_tenth[8] ? 8'hFF : next_tenth[7:0];
			end
		end else begin
			if (key_index == KEY_PAUSE) begin
				hold_d = ~hold_q;
			end else if (key_index == KEY_UP && hold_q) begin
				remaining_d = (sum > MAX_SUM) ? MAX_SUM[CNT_W-1:0] : sum[CNT_W-1:0];
			end else if (key_index == KEY_DOWN && hold_q) begin
				remaining_d = ({2'b00, cfg.adjust_step} < remaining_q)
					? remaining_q - {2'b00, cfg.adjust_step} : '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			remaining_q <= REMAIN_RST;
			hold_q      <= 1'b0;
			tenth_q     <= 8'd0;
			mux_q       <= 4'd0;
			pick_q      <= 1'b0;
		end else if (fire) begin
			remaining_q <= remaining_d;
			hold_q      <= hold_d;
			tenth_q     <= tenth_d;
			mux_q       <= mux_d;
			pick_q      <= pick_d;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			snap_s2.remaining  <= remaining_d;
			snap_s2.digit_pick <= pick_d;
			snap_s2.hold       <= hold_d;
		end
	end

endmodule

// ===== rtl/cdt_disp.sv =====
module cdt_disp (
	input  cdt_pkg::snap_t            snap,
	output logic [cdt_pkg::DIG_W-1:0] digit_enable,
	output logic [cdt_pkg::SEG_W-1:0] segments
);
	import cdt_pkg::*;

	// Digit split by reciprocal multiplication; exact for counts below 1000.
	logic [15:0] hund_prod;
	logic [3:0]  hund;
	logic [6:0]  rem100;
	logic [14:0] tens_prod;
	logic [3:0]  tens;
	logic [3:0]  units;
	logic [CNT_W-1:0] hund_x100;
	logic [6:0]  tens_x10;

	always_comb begin
		hund_prod = {6'd0, snap.remaining} * 16'd41;
		hund      = hund_prod[15:12];
		hund_x100 = CNT_W'({6'd0, hund} * 10'd100);
		rem100    = 7'(snap.remaining - hund_x100);
		tens_prod = {8'd0, rem100} * 15'd205;
		tens      = tens_prod[14:11];
		tens_x10  = 7'({3'd0, tens} * 7'd10);
		units     = 4'(rem100 - tens_x10);

		if (snap.remaining > SPLIT_LIMIT) begin
			segments = snap.digit_pick ? seg_font(tens) : seg_font(hund);
		end else begin
			segments = snap.digit_pick ? seg_font(units) : (seg_font(tens) | SEG_DP);
		end
		digit_enable = snap.digit_pick ? 2'b10 : 2'b01;
	end

endmodule

// ===== rtl/countdown_timer_seven_segment.sv =====
// Channel | Dir | Fields                                        | Accepted when
// req     | in  | req_type, key_index                           | req.valid && req.ready
// res     | out | digit_enable, segments, count_value, paused   | res.valid && res.ready
// cfg     | in  | index, data                                   | cfg.valid && cfg.ready
//
// Each request yields one result, which appears on res after the request has passed
// all three registers. A new request can be taken every cycle while res is not stalled.
// The registers are the input, the state update and the result holding the display decode.
// Reset (arst_n low) restores the count to 200, clears pause and both prescalers,
// and loads the register defaults. A stall on res backs up through the stages,
// and req.ready drops only once every stage holds a transaction.
module countdown_timer_seven_segment #(
	parameter int MAX_COUNT = 999
) (
	input logic      clk,
	input logic      arst_n,
	cdt_req_if.sink  req,
	cdt_res_if.source res,
	cdt_cfg_if.sink  cfg
);
	import cdt_pkg::*;

	// Configuration registers. Writes are always taken; an unknown index is dropped.
	cfg_t cfg_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.tenth_period <= TENTH_PERIOD_RST;
			cfg_q.mux_period   <= MUX_PERIOD_RST;
			cfg_q.adjust_step  <= ADJUST_STEP_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_TENTH_PERIOD: cfg_q.tenth_period <= cfg.data;
				CFG_MUX_PERIOD:   cfg_q.mux_period   <= cfg.data[3:0];
				CFG_ADJUST_STEP:  cfg_q.adjust_step  <= cfg.data;
				default: ;
			endcase
		end
	end

	// Stage handshakes: a stage advances when it is full and the next one is free
	// or emptying in the same cycle.
	logic             valid_s1, valid_s2, res_valid_q;
	logic             req_type_s1;
	logic [KEY_W-1:0] key_index_s1;
	logic             adv_s1, adv_s2;

	assign adv_s2    = valid_s2 && (!res_valid_q || res.ready);
	assign adv_s1    = valid_s1 && (!valid_s2 || adv_s2);
	assign req.ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (req.ready) begin
				valid_s1 <= req.valid;
			end
			if (!valid_s2 || adv_s2) begin
				valid_s2 <= adv_s1;
			end
			if (!res_valid_q || res.ready) begin
				res_valid_q <= adv_s2;
			end
		end
	end

	// Input register.
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			req_type_s1  <= req.req_type;
			key_index_s1 <= req.key_index;
		end
	end

	// The timer state moves only when a request leaves the input register, so
	// requests are applied strictly in order.
	snap_t snap_s2;

	cdt_ctrl #(
		.MAX_COUNT(MAX_COUNT)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (adv_s1),
		.req_type  (req_type_s1),
		.key_index (key_index_s1),
		.cfg       (cfg_q),
		.snap_s2   (snap_s2)
	);

	logic [DIG_W-1:0] digit_enable_c;
	logic [SEG_W-1:0] segments_c;

	cdt_disp u_disp (
		.snap         (snap_s2),
		.digit_enable (digit_enable_c),
		.segments     (segments_c)
	);

	// Result register.
	logic [DIG_W-1:0] digit_enable_q;
	logic [SEG_W-1:0] segments_q;
	logic [CNT_W-1:0] count_value_q;
	logic             paused_q;

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			digit_enable_q <= digit_enable_c;
			segments_q     <= segments_c;
			count_value_q  <= snap_s2.remaining;
			paused_q       <= snap_s2.hold;
		end
	end

	assign res.valid        = res_valid_q;
	assign res.digit_enable = digit_enable_q;
	assign res.segments     = segments_q;
	assign res.count_value  = count_value_q;
	assign res.paused       = paused_q;

endmodule
